### rtl/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants of the knob to MIDI control-change engine.
// ----------------------------------------------------------------------------
package kmc_pkg;

	localparam int DECAY_TICKS_DEF = 50;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0]  STATUS_CC    = 8'hB0;
	localparam logic [13:0] LIMIT_WIDE   = 14'h3FFF;
	localparam logic [13:0] LIMIT_NARROW = 14'h007F;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_DETENT  = 2'd1,
		OP_PRESS   = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_MODE_FLAGS      = 3'd0,
		CFG_MIDI_CHANNELS   = 3'd1,
		CFG_ROTATE_CONTROLS = 3'd2,
		CFG_BUTTON_CONTROLS = 3'd3,
		CFG_ROTATE_STEP     = 3'd4,
		CFG_BUTTON_VALUE_A  = 3'd5,
		CFG_BUTTON_VALUE_B  = 3'd6,
		CFG_ACCEL_AND_ZERO  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		op_t  operation;
		logic clockwise;
	} item_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [6:0] controller;
		logic [6:0] data_value;
		logic       last;
	} packet_t;

	typedef struct packed {
		logic [4:0]  mode_flags;
		logic [7:0]  midi_channels;
		logic [13:0] rotate_controls;
		logic [13:0] button_controls;
		logic [13:0] rotate_step;
		logic [13:0] button_value_a;
		logic [13:0] button_value_b;
		logic [14:0] accel_and_zero;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  chan;
		logic [6:0]  msb_ctl;
		logic [6:0]  lsb_ctl;
		logic [13:0] value;
		logic        wide;
	} cmd_t;

endpackage

### rtl/kmc_regs.sv
// ----------------------------------------------------------------------------
// kmc_regs
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
module kmc_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [14:0]   cfg_data,
	output kmc_pkg::cfg_t cfg
);
	import kmc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_flags      <= 5'd0;
			cfg_q.midi_channels   <= 8'd0;
			cfg_q.rotate_controls <= 14'd7;
			cfg_q.button_controls <= 14'd0;
			cfg_q.rotate_step     <= 14'd1;
			cfg_q.button_value_a  <= 14'd0;
			cfg_q.button_value_b  <= 14'd127;
			cfg_q.accel_and_zero  <= 15'd16384;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MODE_FLAGS:      cfg_q.mode_flags      <= cfg_data[4:0];
				CFG_MIDI_CHANNELS:   cfg_q.midi_channels   <= cfg_data[7:0];
				CFG_ROTATE_CONTROLS: cfg_q.rotate_controls <= cfg_data[13:0];
				CFG_BUTTON_CONTROLS: cfg_q.button_controls <= cfg_data[13:0];
				CFG_ROTATE_STEP:     cfg_q.rotate_step     <= cfg_data[13:0];
				CFG_BUTTON_VALUE_A:  cfg_q.button_value_a  <= cfg_data[13:0];
				CFG_BUTTON_VALUE_B:  cfg_q.button_value_b  <= cfg_data[13:0];
				CFG_ACCEL_AND_ZERO:  cfg_q.accel_and_zero  <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/kmc_front.sv
// ----------------------------------------------------------------------------
// kmc_front
// Event intake: updates knob state, scales the detent step and turns each
// detent, press and momentary release into a packet command for the queue.
// ----------------------------------------------------------------------------
module kmc_front #(
	parameter int DECAY_TICKS = kmc_pkg::DECAY_TICKS_DEF,
	parameter int DEPTH       = kmc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  kmc_pkg::item_t             item,
	output logic                       full,
	input  kmc_pkg::cfg_t              cfg,
	input  logic [$clog2(DEPTH+1)-1:0] cmd_count,
	output logic                       cmd_push,
	output kmc_pkg::cmd_t              cmd
);
	import kmc_pkg::*;

	localparam int         CW       = $clog2(DEPTH + 1);
	localparam logic [5:0] DecayLim = 6'(DECAY_TICKS);

	logic        accept;
	logic        wide_rot, relative, reverse, btn_wide, momentary;
	logic [13:0] limit;
	logic [5:0]  idle_inc;
	logic [14:0] vel_sum;
	logic [13:0] vel_sat;
	logic [14:0] vel_inc;
	logic [28:0] product;

	logic        toggle_q;
	logic [13:0] vel_q;
	logic [5:0]  idle_q;
	logic [6:0]  pos_n_q;
	logic [13:0] pos_w_q;

	logic        valid_s1;
	op_t         op_s1;
	logic        positive_s1;
	logic        use_b_s1;
	logic        send_s1;
	logic [27:0] mag_s1;

	logic [13:0] cur;
	logic [28:0] up;
	logic        under;
	logic [13:0] down;
	logic [13:0] clamped;
	logic [6:0]  zero;
	logic [6:0]  rel7;
	logic        pos_write;

	assign wide_rot  = cfg.mode_flags[0];
	assign relative  = cfg.mode_flags[1];
	assign reverse   = cfg.mode_flags[2];
	assign btn_wide  = cfg.mode_flags[3];
	assign momentary = cfg.mode_flags[4];
	assign limit     = wide_rot ? LIMIT_WIDE : LIMIT_NARROW;

	assign full   = ({1'b0, cmd_count} + (CW+1)'(valid_s1)) >= (CW+1)'(DEPTH);
	assign accept = push && !full;

	assign idle_inc = idle_q + 6'd1;
	assign vel_sum  = {1'b0, vel_q} + {7'd0, cfg.accel_and_zero[7:0]};
	assign vel_sat  = (vel_sum >= {1'b0, limit}) ? limit : vel_sum[13:0];
	assign vel_inc  = {1'b0, vel_q} + 15'd1;
	assign product  = {15'd0, cfg.rotate_step} * {14'd0, vel_inc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_q <= 1'b0;
			vel_q    <= 14'd0;
			idle_q   <= 6'd0;
			pos_n_q  <= 7'd0;
			pos_w_q  <= 14'd0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				unique case (item.operation)
					OP_TICK: begin
						if (idle_inc >= DecayLim) begin
							idle_q <= 6'd0;
							vel_q  <= vel_q >> 1;
						end else begin
							idle_q <= idle_inc;
						end
					end
					OP_DETENT: begin
						vel_q  <= vel_sat;
						idle_q <= 6'd0;
					end
					OP_PRESS: begin
						toggle_q <= ~toggle_q;
						if (idle_q >= DecayLim) begin
							idle_q <= 6'd0;
							vel_q  <= vel_q >> 1;
						end
					end
					OP_RELEASE: begin
						if (idle_q >= DecayLim) begin
							idle_q <= 6'd0;
							vel_q  <= vel_q >> 1;
						end
					end
				endcase
			end
			if (pos_write) begin
				if (wide_rot) begin
					pos_w_q <= clamped;
				end else begin
					pos_n_q <= clamped[6:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= item.operation;
			positive_s1 <= item.clockwise ^ reverse;
			use_b_s1    <= (item.operation == OP_RELEASE) || (!momentary && !toggle_q);
			send_s1     <= (item.operation == OP_DETENT) || (item.operation == OP_PRESS) ||
				((item.operation == OP_RELEASE) && momentary);
			mag_s1      <= product[27:0];
		end
	end

	assign cur   = wide_rot ? pos_w_q : {7'd0, pos_n_q};
	assign up    = {15'd0, cur} + {1'b0, mag_s1};
	assign under = {14'd0, cur} < mag_s1;
	assign down  = cur - mag_s1[13:0];
	assign zero  = cfg.accel_and_zero[14:8];
	assign rel7  = positive_s1 ? (zero + mag_s1[6:0]) : (zero - mag_s1[6:0]);

	always_comb begin
		if (positive_s1) begin
			clamped = (up > {15'd0, limit}) ? limit : up[13:0];
		end else begin
			clamped = under ? 14'd0 : down;
		end
	end

	assign pos_write = valid_s1 && (op_s1 == OP_DETENT) && !relative;
	assign cmd_push  = valid_s1 && send_s1;

	always_comb begin
		priority if (op_s1 == OP_DETENT && relative) begin
			cmd.chan    = cfg.midi_channels[3:0];
			cmd.msb_ctl = cfg.rotate_controls[6:0];
			cmd.lsb_ctl = 7'd0;
			cmd.value   = {7'd0, rel7};
			cmd.wide    = 1'b0;
		end else if (op_s1 == OP_DETENT) begin
			cmd.chan    = cfg.midi_channels[3:0];
			cmd.msb_ctl = cfg.rotate_controls[6:0];
			cmd.lsb_ctl = cfg.rotate_controls[13:7];
			cmd.value   = clamped;
			cmd.wide    = wide_rot;
		end else begin
			cmd.chan    = cfg.midi_channels[7:4];
			cmd.msb_ctl = cfg.button_controls[6:0];
			cmd.lsb_ctl = cfg.button_controls[13:7];
			cmd.value   = use_b_s1 ? cfg.button_value_b : cfg.button_value_a;
			cmd.wide    = btn_wide;
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> cmd_count < CW'(DEPTH))
		else $error("command pushed into a full queue");

	a_detent_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.operation == OP_DETENT |=> idle_q == 6'd0)
		else $error("idle count not cleared by detent");

	a_tick_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.operation == OP_TICK |=> idle_q < DecayLim)
		else $error("idle count reached decay limit after tick");

endmodule

### rtl/kmc_fifo.sv
// ----------------------------------------------------------------------------
// kmc_fifo
// Short command queue between event intake and packet output.
// ----------------------------------------------------------------------------
module kmc_fifo #(
	parameter int DEPTH = kmc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  kmc_pkg::cmd_t              wdata,
	input  logic                       rd_en,
	output kmc_pkg::cmd_t              rdata,
	output logic                       not_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import kmc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign do_wr = wr_en;
	assign do_rd = rd_en && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			priority if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata     = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("command queue overflow");

endmodule

### rtl/kmc_back.sv
// ----------------------------------------------------------------------------
// kmc_back
// Packet output: expands each command into one or two MIDI control-change
// beats and holds them in an output register.
// ----------------------------------------------------------------------------
module kmc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  kmc_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	input  logic             pop,
	output logic             empty,
	output kmc_pkg::packet_t packet
);
	import kmc_pkg::*;

	logic    out_valid_q;
	logic    pend_q;
	packet_t packet_q;
	packet_t lsb_q;
	packet_t msb_pkt;
	packet_t lsb_pkt;
	logic    load;

	assign load    = !out_valid_q || pop;
	assign cmd_pop = load && !pend_q && cmd_valid;

	assign msb_pkt.status_byte = STATUS_CC | {4'd0, cmd.chan};
	assign msb_pkt.controller  = cmd.msb_ctl;
	assign msb_pkt.data_value  = cmd.wide ? cmd.value[13:7] : cmd.value[6:0];
	assign msb_pkt.last        = !cmd.wide;

	assign lsb_pkt.status_byte = STATUS_CC | {4'd0, cmd.chan};
	assign lsb_pkt.controller  = cmd.lsb_ctl;
	assign lsb_pkt.data_value  = cmd.value[6:0];
	assign lsb_pkt.last        = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			priority if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (cmd_valid) begin
				out_valid_q <= 1'b1;
				pend_q      <= cmd.wide;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			priority if (pend_q) begin
				packet_q <= lsb_q;
			end else if (cmd_valid) begin
				packet_q <= msb_pkt;
				lsb_q    <= lsb_pkt;
			end
		end
	end

	assign empty  = !out_valid_q;
	assign packet = packet_q;

	a_first_beat_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !packet_q.last |-> pend_q)
		else $error("first beat of a pair without pending second beat");

endmodule

### rtl/knob_to_midi_cc_engine.sv
// ----------------------------------------------------------------------------
// knob_to_midi_cc_engine
// Knob events in, MIDI control-change packets out.
// Path: an accepted event passes the intake stage register, the command
//   queue and the output register; a 14-bit value's second packet follows.
// Throughput: one event per cycle in while full is low, one packet per
//   cycle out while pop is held; the single output register sets the rate.
// Reset: config registers take their defaults, knob state clears, queues empty.
// ----------------------------------------------------------------------------
module knob_to_midi_cc_engine #(
	parameter int DECAY_TICKS = kmc_pkg::DECAY_TICKS_DEF,
	parameter int QUEUE_DEPTH = kmc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kmc_pkg::item_t   item,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output kmc_pkg::packet_t packet,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [14:0]      cfg_data
);
	import kmc_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cfg_t          cfg;
	cmd_t          wr_cmd;
	cmd_t          rd_cmd;
	logic          cmd_push;
	logic          cmd_pop;
	logic          cmd_valid;
	logic [CW-1:0] cmd_count;

	kmc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kmc_front #(
		.DECAY_TICKS (DECAY_TICKS),
		.DEPTH       (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cfg       (cfg),
		.cmd_count (cmd_count),
		.cmd_push  (cmd_push),
		.cmd       (wr_cmd)
	);

	kmc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cmd_push),
		.wdata     (wr_cmd),
		.rd_en     (cmd_pop),
		.rdata     (rd_cmd),
		.not_empty (cmd_valid),
		.count     (cmd_count)
	);

	kmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (rd_cmd),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.packet    (packet)
	);

endmodule

### tb/knob_to_midi_cc_engine_test.sv
// ----------------------------------------------------------------------------
// knob_to_midi_cc_engine_test
// Self-checking bench for the knob to MIDI control-change engine. A driver
// pushes knob events in random bursts and a monitor pops packets on a
// changing stall pattern. Each accepted event runs through a local model of
// positions, velocity, idle ticks and the toggle. Each popped packet is
// compared with the oldest one due. Registers change only while the engine
// is idle, between phases: directed corner cases first, then random event
// streams under several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module knob_to_midi_cc_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import kmc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	item_t       item = '0;
	logic        full;
	logic        pop = 1'b0;
	logic        empty;
	packet_t     packet;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;

	item_t       events_to_send[$];
	packet_t     packets_due[$];
	int          events_queued = 0;
	int          events_taken = 0;
	int          packets_checked = 0;
	int          errors = 0;

	int          burst_left = 0;
	int          send_gap = 0;
	logic [15:0] stall_pattern = 16'hFFFF;
	int          pattern_age = 0;
	int          hold_off_left = 0;
	bit          hold_off_done = 1'b0;

	cfg_t        reg_mirror = '{mode_flags: 5'd0, midi_channels: 8'd0,
		rotate_controls: 14'd7, button_controls: 14'd0, rotate_step: 14'd1,
		button_value_a: 14'd0, button_value_b: 14'd127,
		accel_and_zero: 15'd16384};
	logic        toggle = 1'b0;
	logic [13:0] velocity = '0;
	logic [5:0]  idle_ticks = '0;
	logic [6:0]  position_narrow = '0;
	logic [13:0] position_wide = '0;

	knob_to_midi_cc_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.pop(pop),
		.empty(empty),
		.packet(packet),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic void queue_cc(logic [3:0] chan, logic [6:0] ctl, logic [6:0] val,
			logic last);
		packet_t p;
		p.status_byte = STATUS_CC | {4'h0, chan};
		p.controller = ctl;
		p.data_value = val;
		p.last = last;
		packets_due.push_back(p);
	endfunction

	function automatic void queue_cc_value(logic [3:0] chan, logic [13:0] controls,
			logic [13:0] val, logic wide);
		if (wide) begin
			queue_cc(chan, controls[6:0], val[13:7], 1'b0);
			queue_cc(chan, controls[13:7], val[6:0], 1'b1);
		end else begin
			queue_cc(chan, controls[6:0], val[6:0], 1'b1);
		end
	endfunction

	function automatic void queue_button(logic use_b);
		queue_cc_value(reg_mirror.midi_channels[7:4], reg_mirror.button_controls,
			use_b ? reg_mirror.button_value_b : reg_mirror.button_value_a,
			reg_mirror.mode_flags[3]);
	endfunction

	function automatic void apply_idle_decay();
		if (idle_ticks >= DECAY_TICKS_DEF) begin
			idle_ticks = '0;
			velocity = velocity >> 1;
		end
	endfunction

	function automatic void predict_cc_packets(item_t it);
		logic       positive;
		logic       wide_rot;
		logic       momentary;
		longint     lim;
		longint     mag;
		longint     pos;
		logic [6:0] zero;
		logic [6:0] sum7;
		int         vel_next;
		wide_rot = reg_mirror.mode_flags[0];
		momentary = reg_mirror.mode_flags[4];
		case (it.operation)
			OP_TICK: begin
				idle_ticks = idle_ticks + 6'd1;
				apply_idle_decay();
			end
			OP_PRESS: begin
				toggle = ~toggle;
				queue_button(!momentary && toggle);
				apply_idle_decay();
			end
			OP_RELEASE: begin
				if (momentary)
					queue_button(1'b1);
				apply_idle_decay();
			end
			OP_DETENT: begin
				positive = it.clockwise ^ reg_mirror.mode_flags[2];
				lim = wide_rot ? longint'(LIMIT_WIDE) : longint'(LIMIT_NARROW);
				mag = longint'(reg_mirror.rotate_step) * (longint'(velocity) + 1);
				if (reg_mirror.mode_flags[1]) begin
					zero = reg_mirror.accel_and_zero[14:8];
					sum7 = positive ? zero + mag[6:0] : zero - mag[6:0];
					queue_cc(reg_mirror.midi_channels[3:0], reg_mirror.rotate_controls[6:0],
						sum7, 1'b1);
				end else begin
					pos = wide_rot ? longint'(position_wide) : longint'(position_narrow);
					pos = positive ? pos + mag : pos - mag;
					if (pos < 0)
						pos = 0;
					else if (pos > lim)
						pos = lim;
					if (wide_rot)
						position_wide = pos[13:0];
					else
						position_narrow = pos[6:0];
					queue_cc_value(reg_mirror.midi_channels[3:0], reg_mirror.rotate_controls,
						pos[13:0], wide_rot);
				end
				vel_next = int'(velocity) + int'(reg_mirror.accel_and_zero[7:0]);
				if (vel_next >= lim)
					vel_next = int'(lim);
				velocity = vel_next[13:0];
				idle_ticks = '0;
			end
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				predict_cc_packets(item);
				events_taken++;
			end
			if (!push || !full) begin
				if (send_gap != 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (events_to_send.size() != 0) begin
					item <= events_to_send.pop_front();
					push <= 1'b1;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
							: $urandom_range(1, 10);
						send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		packet_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (packets_due.size() == 0) begin
					errors++;
					$display("%0t: packet expected none actual %h", $time, packet);
				end else begin
					want = packets_due.pop_front();
					check_field("status_byte", want.status_byte, packet.status_byte);
					check_field("controller", {1'b0, want.controller},
						{1'b0, packet.controller});
					check_field("data_value", {1'b0, want.data_value},
						{1'b0, packet.data_value});
					check_field("last", {7'd0, want.last}, {7'd0, packet.last});
				end
				packets_checked++;
			end
			if (hold_off_left != 0) begin
				hold_off_left--;
				pop <= 1'b0;
			end else if (!hold_off_done && events_to_send.size() > 40
					&& packets_checked >= 20) begin
				hold_off_done = 1'b1;
				hold_off_left = 200;
				pop <= 1'b0;
			end else begin
				pop <= stall_pattern[0];
				stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
				pattern_age++;
				if (pattern_age == 48) begin
					pattern_age = 0;
					case ($urandom_range(0, 3))
						0: stall_pattern = 16'hFFFF;
						1: stall_pattern = 16'($urandom);
						2: stall_pattern = 16'($urandom | $urandom);
						default: stall_pattern = 16'($urandom & $urandom);
					endcase
					if (stall_pattern == '0)
						stall_pattern[0] = 1'b1;
				end
			end
		end
	end

	task automatic add_item(op_t op, logic cw);
		events_to_send.push_back('{operation: op, clockwise: cw});
		events_queued++;
	endtask

	task automatic wait_idle();
		while (events_taken != events_queued || packets_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [14:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_MODE_FLAGS:      reg_mirror.mode_flags = value[4:0];
			CFG_MIDI_CHANNELS:   reg_mirror.midi_channels = value[7:0];
			CFG_ROTATE_CONTROLS: reg_mirror.rotate_controls = value[13:0];
			CFG_BUTTON_CONTROLS: reg_mirror.button_controls = value[13:0];
			CFG_ROTATE_STEP:     reg_mirror.rotate_step = value[13:0];
			CFG_BUTTON_VALUE_A:  reg_mirror.button_value_a = value[13:0];
			CFG_BUTTON_VALUE_B:  reg_mirror.button_value_b = value[13:0];
			CFG_ACCEL_AND_ZERO:  reg_mirror.accel_and_zero = value;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic start_phase(cfg_t c);
		wait_idle();
		write_reg(CFG_MODE_FLAGS, {10'd0, c.mode_flags});
		write_reg(CFG_MIDI_CHANNELS, {7'd0, c.midi_channels});
		write_reg(CFG_ROTATE_CONTROLS, {1'b0, c.rotate_controls});
		write_reg(CFG_BUTTON_CONTROLS, {1'b0, c.button_controls});
		write_reg(CFG_ROTATE_STEP, {1'b0, c.rotate_step});
		write_reg(CFG_BUTTON_VALUE_A, {1'b0, c.button_value_a});
		write_reg(CFG_BUTTON_VALUE_B, {1'b0, c.button_value_b});
		write_reg(CFG_ACCEL_AND_ZERO, c.accel_and_zero);
		@(negedge clk);
	endtask

	function automatic cfg_t random_settings(int phase);
		cfg_t c;
		c.mode_flags = {3'($urandom), 2'(phase)};
		c.midi_channels = 8'($urandom);
		c.rotate_controls = 14'($urandom);
		c.button_controls = 14'($urandom);
		case ($urandom_range(0, 7))
			0: c.rotate_step = '0;
			1: c.rotate_step = '1;
			2: c.rotate_step = 14'($urandom);
			default: c.rotate_step = 14'($urandom_range(1, 12));
		endcase
		c.button_value_a = 14'($urandom);
		c.button_value_b = 14'($urandom);
		c.accel_and_zero[14:8] = 7'($urandom);
		case ($urandom_range(0, 5))
			0: c.accel_and_zero[7:0] = 8'd0;
			1: c.accel_and_zero[7:0] = 8'd255;
			default: c.accel_and_zero[7:0] = 8'($urandom_range(1, 6));
		endcase
		return c;
	endfunction

	task automatic add_random_events(int count);
		int   added;
		int   run;
		logic dir;
		added = 0;
		while (added < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					run = $urandom_range(1, 8);
					dir = 1'($urandom);
					repeat (run)
						add_item(OP_DETENT, ($urandom_range(0, 7) == 0) ? ~dir : dir);
					added += run;
				end
				4, 5: begin
					run = ($urandom_range(0, 3) == 0) ? $urandom_range(45, 60)
						: $urandom_range(1, 6);
					repeat (run)
						add_item(OP_TICK, 1'($urandom));
					added += run;
				end
				6, 7: begin
					run = $urandom_range(0, 3);
					add_item(OP_PRESS, 1'($urandom));
					repeat (run)
						add_item(OP_TICK, 1'($urandom));
					add_item(OP_RELEASE, 1'($urandom));
					added += run + 2;
				end
				default: begin
					add_item(op_t'($urandom_range(0, 3)), 1'($urandom));
					added++;
				end
			endcase
		end
	endtask

	initial begin
		cfg_t c;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_item(OP_DETENT, 1'b0);
		add_item(OP_DETENT, 1'b1);
		add_item(OP_DETENT, 1'b1);
		add_item(OP_PRESS, 1'b0);
		add_item(OP_RELEASE, 1'b1);
		add_item(OP_PRESS, 1'b1);
		add_item(OP_TICK, 1'b1);

		c = '0;
		c.mode_flags = 5'b11000;
		c.midi_channels = 8'hFF;
		c.button_controls = '1;
		c.rotate_step = 14'd1;
		c.button_value_a = '1;
		start_phase(c);
		add_item(OP_PRESS, 1'b0);
		add_item(OP_RELEASE, 1'b0);
		add_item(OP_PRESS, 1'b1);
		add_item(OP_RELEASE, 1'b1);

		c = '0;
		c.mode_flags = 5'b00001;
		c.midi_channels = 8'h0F;
		c.rotate_controls = '1;
		c.rotate_step = '1;
		c.accel_and_zero = 15'h00FF;
		start_phase(c);
		add_item(OP_DETENT, 1'b1);
		add_item(OP_DETENT, 1'b1);
		add_item(OP_DETENT, 1'b0);
		add_item(OP_DETENT, 1'b0);
		add_item(OP_TICK, 1'b0);

		c.mode_flags = 5'b00110;
		c.rotate_step = 14'd5;
		c.accel_and_zero = '1;
		start_phase(c);
		add_item(OP_DETENT, 1'b1);
		add_item(OP_DETENT, 1'b0);
		add_item(OP_DETENT, 1'b1);
		add_item(OP_DETENT, 1'b0);

		c.mode_flags = '0;
		c.rotate_step = '1;
		c.accel_and_zero = '0;
		start_phase(c);
		add_item(OP_DETENT, 1'b1);
		add_item(OP_DETENT, 1'b0);

		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 0)
				c = '0;
			else if (phase == 7)
				c = '1;
			else
				c = random_settings(phase);
			start_phase(c);
			add_random_events(160);
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
